// File: rtl/ycbcr420_block_to_rgb_macros.svh
// Assertion macros used by the port checker of the block.
`ifndef YCBCR420_BLOCK_TO_RGB_MACROS_SVH
`define YCBCR420_BLOCK_TO_RGB_MACROS_SVH

// Antecedent implies consequent in the same cycle, masked while in reset.
`define YCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle, masked while in reset.
`define YCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/ycc2rgb_pkg.sv
`default_nettype none

package ycc2rgb_pkg;

   localparam int PIX_W      = 8;   // one sample or one colour value
   localparam int SMP_W      = 9;   // sample with offset removed, signed
   localparam int COEF_W     = 15;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int PROD_W     = 25;  // coefficient times signed sample
   localparam int ACC_W      = 33;  // sum plus a rounding term up to 2^30

   localparam int LUMA_OFFSET   = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int PIXEL_MAX     = 255;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_LUMA_GAIN   = 3'd0;
   localparam csr_index_type REG_CR_TO_RED   = 3'd1;
   localparam csr_index_type REG_CR_TO_GREEN = 3'd2;
   localparam csr_index_type REG_CB_TO_GREEN = 3'd3;
   localparam csr_index_type REG_CB_TO_BLUE  = 3'd4;
   localparam csr_index_type REG_FRAC_BITS   = 3'd5;

   typedef struct packed {
      logic [COEF_W-1:0]  luma_gain;
      logic [COEF_W-1:0]  cr_to_red;
      logic [COEF_W-1:0]  cr_to_green;
      logic [COEF_W-1:0]  cb_to_green;
      logic [COEF_W-1:0]  cb_to_blue;
      logic [SHIFT_W-1:0] frac_bits;
   } coef_type;

   localparam coef_type COEF_RESET = '{
      luma_gain:   15'd9535,
      cr_to_red:   15'd13074,
      cr_to_green: 15'd6660,
      cb_to_green: 15'd3203,
      cb_to_blue:  15'd16531,
      frac_bits:   5'd13
   };

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

// File: rtl/ycbcr420_block_to_rgb.sv
`default_nettype none

// 2x2 YCbCr 4:2:0 block to RGB converter.
//
// Input: one word per block (four luma samples, four Cb and four Cr samples
// around the block's chroma site). A word is taken on a clock edge with start
// high and busy low. busy is low except during reset, so a new block can be
// offered on every cycle.
// Output: rsp_valid is high for one cycle with twelve 8-bit colour values.
// There is no back-pressure; the receiver must take each word as it comes.
// Throughput is one block per cycle; accept to strobe passes through
// upsample/offset, multiply, sum+round, shift+clamp, one register each, in
// four parallel pixel lanes with five multipliers per lane.
// Config: csr_valid/csr_ready write port, csr_index selects the gain or the
// shift register, unknown indexes are dropped. Change registers only while
// the pipeline is empty.
// Reset (synchronous) empties the pipeline and loads the default BT.601
// coefficients; words in flight are dropped and nothing is taken meanwhile.
module ycbcr420_block_to_rgb
   import ycc2rgb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // block input
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PIX_W-1:0]      req_y_top_left,
   input  wire logic [PIX_W-1:0]      req_y_top_right,
   input  wire logic [PIX_W-1:0]      req_y_bottom_left,
   input  wire logic [PIX_W-1:0]      req_y_bottom_right,
   input  wire logic [PIX_W-1:0]      req_cb_here,
   input  wire logic [PIX_W-1:0]      req_cb_right,
   input  wire logic [PIX_W-1:0]      req_cb_below,
   input  wire logic [PIX_W-1:0]      req_cb_diagonal,
   input  wire logic [PIX_W-1:0]      req_cr_here,
   input  wire logic [PIX_W-1:0]      req_cr_right,
   input  wire logic [PIX_W-1:0]      req_cr_below,
   input  wire logic [PIX_W-1:0]      req_cr_diagonal,

   // RGB output
   output logic                       rsp_valid,
   output logic [PIX_W-1:0]           rsp_red_top_left,
   output logic [PIX_W-1:0]           rsp_green_top_left,
   output logic [PIX_W-1:0]           rsp_blue_top_left,
   output logic [PIX_W-1:0]           rsp_red_top_right,
   output logic [PIX_W-1:0]           rsp_green_top_right,
   output logic [PIX_W-1:0]           rsp_blue_top_right,
   output logic [PIX_W-1:0]           rsp_red_bottom_left,
   output logic [PIX_W-1:0]           rsp_green_bottom_left,
   output logic [PIX_W-1:0]           rsp_blue_bottom_left,
   output logic [PIX_W-1:0]           rsp_red_bottom_right,
   output logic [PIX_W-1:0]           rsp_green_bottom_right,
   output logic [PIX_W-1:0]           rsp_blue_bottom_right,

   // register write port
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NUM_PX = 4;   // TL, TR, BL, BR
   localparam int DEPTH  = 4;   // register stages from accept to strobe

   logic accept;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   coef_type coef_ff, coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LUMA_GAIN:   coef_in.luma_gain   = csr_data[COEF_W-1:0];
            REG_CR_TO_RED:   coef_in.cr_to_red   = csr_data[COEF_W-1:0];
            REG_CR_TO_GREEN: coef_in.cr_to_green = csr_data[COEF_W-1:0];
            REG_CB_TO_GREEN: coef_in.cb_to_green = csr_data[COEF_W-1:0];
            REG_CB_TO_BLUE:  coef_in.cb_to_blue  = csr_data[COEF_W-1:0];
            REG_FRAC_BITS:   coef_in.frac_bits   = csr_data[SHIFT_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // ---------------------------------------------------------------
   // Valid bits travel alongside the data
   // ---------------------------------------------------------------
   logic [DEPTH-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[DEPTH-1];

   // ---------------------------------------------------------------
   // Stage 1: chroma upsampling and offset removal
   // ---------------------------------------------------------------
   // Two-sample averages keep the top 8 bits of a 9-bit sum, the
   // four-sample average the top 8 bits of a 10-bit sum (truncating).
   logic [PIX_W:0]   cb_tr_sum, cb_bl_sum, cr_tr_sum, cr_bl_sum;
   logic [PIX_W+1:0] cb_br_sum, cr_br_sum;
   logic [PIX_W-1:0] luma_up [NUM_PX];
   logic [PIX_W-1:0] cb_up   [NUM_PX];
   logic [PIX_W-1:0] cr_up   [NUM_PX];

   logic signed [SMP_W-1:0] y_ff  [NUM_PX];
   logic signed [SMP_W-1:0] cb_ff [NUM_PX];
   logic signed [SMP_W-1:0] cr_ff [NUM_PX];

   always_comb begin
      cb_tr_sum = {1'b0, req_cb_here} + {1'b0, req_cb_right};
      cb_bl_sum = {1'b0, req_cb_here} + {1'b0, req_cb_below};
      cb_br_sum = {2'b0, req_cb_here} + {2'b0, req_cb_right}
                + {2'b0, req_cb_below} + {2'b0, req_cb_diagonal};
      cr_tr_sum = {1'b0, req_cr_here} + {1'b0, req_cr_right};
      cr_bl_sum = {1'b0, req_cr_here} + {1'b0, req_cr_below};
      cr_br_sum = {2'b0, req_cr_here} + {2'b0, req_cr_right}
                + {2'b0, req_cr_below} + {2'b0, req_cr_diagonal};

      luma_up[0] = req_y_top_left;
      luma_up[1] = req_y_top_right;
      luma_up[2] = req_y_bottom_left;
      luma_up[3] = req_y_bottom_right;

      cb_up[0] = req_cb_here;
      cb_up[1] = cb_tr_sum[PIX_W:1];
      cb_up[2] = cb_bl_sum[PIX_W:1];
      cb_up[3] = cb_br_sum[PIX_W+1:2];

      cr_up[0] = req_cr_here;
      cr_up[1] = cr_tr_sum[PIX_W:1];
      cr_up[2] = cr_bl_sum[PIX_W:1];
      cr_up[3] = cr_br_sum[PIX_W+1:2];
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PX; p++) begin
         y_ff[p]  <= {1'b0, luma_up[p]} - SMP_W'(LUMA_OFFSET);
         cb_ff[p] <= {1'b0, cb_up[p]}   - SMP_W'(CHROMA_OFFSET);
         cr_ff[p] <= {1'b0, cr_up[p]}   - SMP_W'(CHROMA_OFFSET);
      end
   end

   // ---------------------------------------------------------------
   // Stages 2..4: one colour lane per pixel
   // ---------------------------------------------------------------
   rgb_type px_rgb [NUM_PX];

   for (genvar p = 0; p < NUM_PX; p++) begin : g_lane
      ycc2rgb_pixel u_pixel (
         .clock (clock),
         .y     (y_ff[p]),
         .cb    (cb_ff[p]),
         .cr    (cr_ff[p]),
         .coef  (coef_ff),
         .rgb   (px_rgb[p])
      );
   end

   assign rsp_red_top_left       = px_rgb[0].red;
   assign rsp_green_top_left     = px_rgb[0].green;
   assign rsp_blue_top_left      = px_rgb[0].blue;
   assign rsp_red_top_right      = px_rgb[1].red;
   assign rsp_green_top_right    = px_rgb[1].green;
   assign rsp_blue_top_right     = px_rgb[1].blue;
   assign rsp_red_bottom_left    = px_rgb[2].red;
   assign rsp_green_bottom_left  = px_rgb[2].green;
   assign rsp_blue_bottom_left   = px_rgb[2].blue;
   assign rsp_red_bottom_right   = px_rgb[3].red;
   assign rsp_green_bottom_right = px_rgb[3].green;
   assign rsp_blue_bottom_right  = px_rgb[3].blue;

endmodule

`default_nettype wire

// File: rtl/ycc2rgb_pixel.sv
`default_nettype none

// One pixel lane: products, sums with rounding, shift and clamp.
module ycc2rgb_pixel
   import ycc2rgb_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic signed [SMP_W-1:0] y,
   input  wire logic signed [SMP_W-1:0] cb,
   input  wire logic signed [SMP_W-1:0] cr,
   input  wire coef_type                coef,
   output rgb_type                      rgb
);

   function automatic logic [PIX_W-1:0] clamp_px(input logic signed [ACC_W-1:0] q);
      logic [PIX_W-1:0] res;
      if (q[ACC_W-1]) begin
         res = '0;
      end else if (q[ACC_W-2:0] > (ACC_W-1)'(PIXEL_MAX)) begin
         res = PIX_W'(PIXEL_MAX);
      end else begin
         res = q[PIX_W-1:0];
      end
      return res;
   endfunction

   // stage A: products
   logic signed [PROD_W-1:0] base_ff, crr_ff, crg_ff, cbg_ff, cbb_ff;

   always_ff @(posedge clock) begin
      base_ff <= PROD_W'($signed({1'b0, coef.luma_gain}))   * PROD_W'(y);
      crr_ff  <= PROD_W'($signed({1'b0, coef.cr_to_red}))   * PROD_W'(cr);
      crg_ff  <= PROD_W'($signed({1'b0, coef.cr_to_green})) * PROD_W'(cr);
      cbg_ff  <= PROD_W'($signed({1'b0, coef.cb_to_green})) * PROD_W'(cb);
      cbb_ff  <= PROD_W'($signed({1'b0, coef.cb_to_blue}))  * PROD_W'(cb);
   end

   // stage B: sums plus half an LSB of the output
   logic signed [ACC_W-1:0] round_c;
   logic signed [ACC_W-1:0] red_acc_ff, green_acc_ff, blue_acc_ff;

   always_comb begin
      if (coef.frac_bits == '0) begin
         round_c = '0;
      end else begin
         round_c = ACC_W'(1) << (coef.frac_bits - SHIFT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      red_acc_ff   <= ACC_W'(base_ff) + ACC_W'(crr_ff) + round_c;
      green_acc_ff <= ACC_W'(base_ff) - ACC_W'(crg_ff) - ACC_W'(cbg_ff) + round_c;
      blue_acc_ff  <= ACC_W'(base_ff) + ACC_W'(cbb_ff) + round_c;
   end

   // stage C: floor shift and clamp
   rgb_type rgb_ff;

   always_ff @(posedge clock) begin
      rgb_ff.red   <= clamp_px(red_acc_ff   >>> coef.frac_bits);
      rgb_ff.green <= clamp_px(green_acc_ff >>> coef.frac_bits);
      rgb_ff.blue  <= clamp_px(blue_acc_ff  >>> coef.frac_bits);
   end

   assign rgb = rgb_ff;

endmodule

`default_nettype wire

// File: rtl/ycc2rgb_checker.sv
`default_nettype none

`include "ycbcr420_block_to_rgb_macros.svh"

// Port-level checks: ports open out of reset, one strobe per accepted word and none without one, reset flushes.
module ycc2rgb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic csr_ready,
   input wire logic rsp_valid
);

   // accept history, cleared by reset like the pipeline's valid bits
   logic [3:0] acc_hist_ff, acc_hist_in;
   logic       acc_seen;

   assign acc_hist_in = {acc_hist_ff[2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_hist_ff <= '0;
      end else begin
         acc_hist_ff <= acc_hist_in;
      end
   end

   assign acc_seen = acc_hist_ff[3];

   `YCC_ASSERT_SAME(a_open_out_of_reset, clock, reset, 1'b1, !busy && csr_ready)
   `YCC_ASSERT_SAME(a_word_out_after_four, clock, reset, acc_seen, rsp_valid)
   `YCC_ASSERT_SAME(a_no_spurious_word, clock, reset, rsp_valid, $past(start && !busy, 4))
   `YCC_ASSERT_NEXT(a_reset_flushes, clock, reset, $past(reset, 1), !rsp_valid)

endmodule

bind ycbcr420_block_to_rgb ycc2rgb_checker u_checker (.*);

`default_nettype wire

// File: dv/ycbcr420_block_to_rgb_tb.sv
`timescale 1ns / 1ps

module ycbcr420_block_to_rgb_tb;
   import ycc2rgb_pkg::*;

   // Pipeline depth from accept to strobe, plus a little slack
   localparam int LATENCY       = 4;
   localparam int SETTLE_CYCLES = LATENCY + 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 9;
   localparam int PHASE_WORDS   = 115;
   localparam int DIRECTED_ROWS = 12;

   // Pixel positions within the 2x2 block, and chroma site positions
   localparam int PIX_TL = 0;
   localparam int PIX_TR = 1;
   localparam int PIX_BL = 2;
   localparam int PIX_BR = 3;
   localparam int SITE_HERE  = 0;
   localparam int SITE_RIGHT = 1;
   localparam int SITE_BELOW = 2;
   localparam int SITE_DIAG  = 3;

   // Indexes past the register file; writes to them must be dropped
   localparam csr_index_type REG_UNMAPPED_LO = 3'd6;
   localparam csr_index_type REG_UNMAPPED_HI = 3'd7;

   // One input word: luma by pixel position, chroma by site position
   typedef struct packed {
      logic [3:0][PIX_W-1:0] y;
      logic [3:0][PIX_W-1:0] cb;
      logic [3:0][PIX_W-1:0] cr;
   } ycc_block_type;

   typedef rgb_type [3:0] rgb_quad_type;

   typedef struct packed {
      ycc_block_type blk;
      bit            known;
      rgb_quad_type  rgb;
   } directed_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [PIX_W-1:0] req_y_top_left, req_y_top_right, req_y_bottom_left, req_y_bottom_right;
   logic [PIX_W-1:0] req_cb_here, req_cb_right, req_cb_below, req_cb_diagonal;
   logic [PIX_W-1:0] req_cr_here, req_cr_right, req_cr_below, req_cr_diagonal;
   logic rsp_valid;
   logic [PIX_W-1:0] rsp_red_top_left, rsp_green_top_left, rsp_blue_top_left;
   logic [PIX_W-1:0] rsp_red_top_right, rsp_green_top_right, rsp_blue_top_right;
   logic [PIX_W-1:0] rsp_red_bottom_left, rsp_green_bottom_left, rsp_blue_bottom_left;
   logic [PIX_W-1:0] rsp_red_bottom_right, rsp_green_bottom_right, rsp_blue_bottom_right;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow of the coefficient registers, updated on each accepted write
   coef_type coef_now = COEF_RESET;
   // Colours still owed by the block, oldest first
   rgb_quad_type pending_rgb [$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int colour_errors = 0;
   int unsigned cycle_count = 0;
   string pixel_name [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

   ycbcr420_block_to_rgb dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_y_top_left         (req_y_top_left),
      .req_y_top_right        (req_y_top_right),
      .req_y_bottom_left      (req_y_bottom_left),
      .req_y_bottom_right     (req_y_bottom_right),
      .req_cb_here            (req_cb_here),
      .req_cb_right           (req_cb_right),
      .req_cb_below           (req_cb_below),
      .req_cb_diagonal        (req_cb_diagonal),
      .req_cr_here            (req_cr_here),
      .req_cr_right           (req_cr_right),
      .req_cr_below           (req_cr_below),
      .req_cr_diagonal        (req_cr_diagonal),
      .rsp_valid              (rsp_valid),
      .rsp_red_top_left       (rsp_red_top_left),
      .rsp_green_top_left     (rsp_green_top_left),
      .rsp_blue_top_left      (rsp_blue_top_left),
      .rsp_red_top_right      (rsp_red_top_right),
      .rsp_green_top_right    (rsp_green_top_right),
      .rsp_blue_top_right     (rsp_blue_top_right),
      .rsp_red_bottom_left    (rsp_red_bottom_left),
      .rsp_green_bottom_left  (rsp_green_bottom_left),
      .rsp_blue_bottom_left   (rsp_blue_bottom_left),
      .rsp_red_bottom_right   (rsp_red_bottom_right),
      .rsp_green_bottom_right (rsp_green_bottom_right),
      .rsp_blue_bottom_right  (rsp_blue_bottom_right),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Colour predictor
   // ---------------------------------------------------------------------

   // Add half an LSB, floor-shift by frac_bits (zero means neither), clamp.
   // longint holds every sum exactly, even with a rounding term of 2^30.
   function automatic logic [PIX_W-1:0] round_clamp(longint acc);
      longint v;
      v = acc;
      if (coef_now.frac_bits != 0)
         v += longint'(1) << (coef_now.frac_bits - 1);
      v = v >>> coef_now.frac_bits;
      if (v < 0)
         return '0;
      if (v > PIXEL_MAX)
         return PIX_W'(PIXEL_MAX);
      return v[PIX_W-1:0];
   endfunction

   function automatic rgb_type pixel_rgb(logic [PIX_W-1:0] yv, logic [PIX_W-1:0] cbv,
                                         logic [PIX_W-1:0] crv);
      longint y, cb, cr, base;
      rgb_type px;
      y    = yv;
      cb   = cbv;
      cr   = crv;
      y    = y - LUMA_OFFSET;
      cb   = cb - CHROMA_OFFSET;
      cr   = cr - CHROMA_OFFSET;
      base = longint'(coef_now.luma_gain) * y;
      px.red   = round_clamp(base + longint'(coef_now.cr_to_red) * cr);
      px.green = round_clamp(base - longint'(coef_now.cr_to_green) * cr
                                  - longint'(coef_now.cb_to_green) * cb);
      px.blue  = round_clamp(base + longint'(coef_now.cb_to_blue) * cb);
      return px;
   endfunction

   // 4:2:0 upsampling of one plane, truncated averages
   function automatic logic [3:0][PIX_W-1:0] upsample(logic [3:0][PIX_W-1:0] s);
      logic [3:0][PIX_W-1:0] u;
      u[PIX_TL] = s[SITE_HERE];
      u[PIX_TR] = PIX_W'((int'(s[SITE_HERE]) + s[SITE_RIGHT]) >> 1);
      u[PIX_BL] = PIX_W'((int'(s[SITE_HERE]) + s[SITE_BELOW]) >> 1);
      u[PIX_BR] = PIX_W'((int'(s[SITE_HERE]) + s[SITE_RIGHT] + s[SITE_BELOW]
                          + s[SITE_DIAG]) >> 2);
      return u;
   endfunction

   function automatic rgb_quad_type block_colours(ycc_block_type b);
      logic [3:0][PIX_W-1:0] cbu, cru;
      rgb_quad_type q;
      cbu = upsample(b.cb);
      cru = upsample(b.cr);
      for (int p = 0; p < 4; p++)
         q[p] = pixel_rgb(b.y[p], cbu[p], cru[p]);
      return q;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Low byte of each argument is top-left pixel / chroma site here
   function automatic ycc_block_type block_of(logic [31:0] y, logic [31:0] cb,
                                              logic [31:0] cr);
      ycc_block_type b;
      b.y  = y;
      b.cb = cb;
      b.cr = cr;
      return b;
   endfunction

   // Mix of uniform noise, smooth video-range content and extreme codes
   function automatic ycc_block_type random_block();
      ycc_block_type b;
      int mode;
      mode = $urandom_range(0, 2);
      b = {$urandom(), $urandom(), $urandom()};
      if (mode == 1) begin
         // video range, neighbouring chroma close to the centre sample
         for (int p = 0; p < 4; p++)
            b.y[p] = PIX_W'($urandom_range(16, 235));
         b.cb[SITE_HERE] = PIX_W'($urandom_range(16, 240));
         b.cr[SITE_HERE] = PIX_W'($urandom_range(16, 240));
         for (int s = SITE_RIGHT; s <= SITE_DIAG; s++) begin
            b.cb[s] = PIX_W'(int'(b.cb[SITE_HERE]) + int'($urandom_range(0, 24)) - 12);
            b.cr[s] = PIX_W'(int'(b.cr[SITE_HERE]) + int'($urandom_range(0, 24)) - 12);
         end
      end else if (mode == 2) begin
         // each sample may be set to 0, 255 or the black/neutral level, else kept
         for (int p = 0; p < 4; p++) begin
            case ($urandom_range(0, 4))
               0: b.y[p] = 8'd0;
               1: b.y[p] = 8'd255;
               2: b.y[p] = 8'd16;
               default: ;
            endcase
            case ($urandom_range(0, 4))
               0: b.cb[p] = 8'd0;
               1: b.cb[p] = 8'd255;
               2: b.cb[p] = 8'd128;
               default: ;
            endcase
            case ($urandom_range(0, 4))
               0: b.cr[p] = 8'd0;
               1: b.cr[p] = 8'd255;
               2: b.cr[p] = 8'd128;
               default: ;
            endcase
         end
      end
      return b;
   endfunction

   task automatic drive_fields(ycc_block_type b);
      req_y_top_left     <= b.y[PIX_TL];
      req_y_top_right    <= b.y[PIX_TR];
      req_y_bottom_left  <= b.y[PIX_BL];
      req_y_bottom_right <= b.y[PIX_BR];
      req_cb_here        <= b.cb[SITE_HERE];
      req_cb_right       <= b.cb[SITE_RIGHT];
      req_cb_below       <= b.cb[SITE_BELOW];
      req_cb_diagonal    <= b.cb[SITE_DIAG];
      req_cr_here        <= b.cr[SITE_HERE];
      req_cr_right       <= b.cr[SITE_RIGHT];
      req_cr_below       <= b.cr[SITE_BELOW];
      req_cr_diagonal    <= b.cr[SITE_DIAG];
   endtask

   // Entered and left at a falling edge. Idle cycles carry junk on the
   // fields with start low; the word is queued only once it is taken.
   task automatic send_word(ycc_block_type b, rgb_quad_type colours, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         drive_fields(random_block());
         @(negedge clock);
      end
      start <= 1'b1;
      drive_fields(b);
      do
         @(posedge clock);
      while (busy);
      pending_rgb.push_back(colours);
      @(negedge clock);
   endtask

   // Entered and left at a falling edge; caller drops csr_valid afterwards
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_LUMA_GAIN:   coef_now.luma_gain   = value;
         REG_CR_TO_RED:   coef_now.cr_to_red   = value;
         REG_CR_TO_GREEN: coef_now.cr_to_green = value;
         REG_CB_TO_GREEN: coef_now.cb_to_green = value;
         REG_CB_TO_BLUE:  coef_now.cb_to_blue  = value;
         REG_FRAC_BITS:   coef_now.frac_bits   = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Let the pipeline empty before touching the registers
   task automatic drain();
      while (pending_rgb.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Register set for each phase: extremes of the gains, zero shift,
   // shifts past 16 (upper data bits set), writes to unmapped indexes
   task automatic configure(int phase);
      logic [COEF_W-1:0] gain [5];
      logic [CSR_DATA_W-1:0] shift_word;
      int k;
      foreach (gain[i])
         gain[i] = COEF_W'($urandom_range(0, 32767));
      shift_word = CSR_DATA_W'($urandom);
      case (phase)
         1: begin
            foreach (gain[i]) gain[i] = '1;
            shift_word = 15'd16;
         end
         2: begin
            foreach (gain[i]) gain[i] = '0;
            shift_word = 15'd1;
         end
         3: begin
            // zero shift, with tiny gains of 0 to 2
            foreach (gain[i]) gain[i] = COEF_W'($urandom_range(0, 2));
            shift_word = 15'd0;
         end
         4: begin
            foreach (gain[i]) gain[i] = '1;
            shift_word = '1;
         end
         5: shift_word = {10'($urandom), 5'($urandom_range(17, 30))};
         6: begin
            write_reg(REG_UNMAPPED_LO, CSR_DATA_W'($urandom));
            write_reg(REG_UNMAPPED_HI, CSR_DATA_W'($urandom));
            gain[0] = COEF_RESET.luma_gain;
            gain[1] = COEF_RESET.cr_to_red;
            gain[2] = COEF_RESET.cr_to_green;
            gain[3] = COEF_RESET.cb_to_green;
            gain[4] = COEF_RESET.cb_to_blue;
            shift_word = CSR_DATA_W'(COEF_RESET.frac_bits);
         end
         7: begin
            // gains scaled to the shift so that colours stay mostly in range
            k = $urandom_range(10, 15);
            foreach (gain[i]) gain[i] = COEF_W'($urandom_range(0, (1 << (k + 1)) - 1));
            shift_word = CSR_DATA_W'(k);
         end
         default: ;
      endcase
      write_reg(REG_LUMA_GAIN, gain[0]);
      write_reg(REG_CR_TO_RED, gain[1]);
      write_reg(REG_CR_TO_GREEN, gain[2]);
      write_reg(REG_CB_TO_GREEN, gain[3]);
      write_reg(REG_CB_TO_BLUE, gain[4]);
      write_reg(REG_FRAC_BITS, shift_word);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest owed word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rgb_quad_type got, want;
      if (!reset && rsp_valid) begin
         got[PIX_TL] = {rsp_red_top_left, rsp_green_top_left, rsp_blue_top_left};
         got[PIX_TR] = {rsp_red_top_right, rsp_green_top_right, rsp_blue_top_right};
         got[PIX_BL] = {rsp_red_bottom_left, rsp_green_bottom_left, rsp_blue_bottom_left};
         got[PIX_BR] = {rsp_red_bottom_right, rsp_green_bottom_right,
                        rsp_blue_bottom_right};
         if (pending_rgb.size() == 0) begin
            colour_errors++;
            $display("%0t: unexpected word, got %h", $time, got);
         end else begin
            want = pending_rgb.pop_front();
            for (int p = 0; p < 4; p++) begin
               if (got[p].red !== want[p].red) begin
                  colour_errors++;
                  $display("%0t: red_%s expected %0d got %0d", $time, pixel_name[p],
                           want[p].red, got[p].red);
               end
               if (got[p].green !== want[p].green) begin
                  colour_errors++;
                  $display("%0t: green_%s expected %0d got %0d", $time, pixel_name[p],
                           want[p].green, got[p].green);
               end
               if (got[p].blue !== want[p].blue) begin
                  colour_errors++;
                  $display("%0t: blue_%s expected %0d got %0d", $time, pixel_name[p],
                           want[p].blue, got[p].blue);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      ycc_block_type blk;
      int idle_pct;

      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_LUMA_GAIN;
      csr_data  = '0;
      drive_fields('0);

      // Directed words at reset coefficients. Rows with a typed-in answer:
      // black level, saturated white and sub-black luma with neutral chroma.
      directed_rows[0]  = '{block_of(32'h10101010, 32'h80808080, 32'h80808080), 1'b1, '0};
      directed_rows[1]  = '{block_of(32'hFFFFFFFF, 32'h80808080, 32'h80808080), 1'b1, '1};
      directed_rows[2]  = '{block_of(32'h00000000, 32'h80808080, 32'h80808080), 1'b1, '0};
      // chroma extremes, both planes
      directed_rows[3]  = '{block_of(32'h00000000, 32'h00000000, 32'h00000000), 1'b0, '0};
      directed_rows[4]  = '{block_of(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 1'b0, '0};
      directed_rows[5]  = '{block_of(32'h80808080, 32'h00000000, 32'hFFFFFFFF), 1'b0, '0};
      directed_rows[6]  = '{block_of(32'h80808080, 32'hFFFFFFFF, 32'h00000000), 1'b0, '0};
      // odd neighbour sums, truncation in every average
      directed_rows[7]  = '{block_of(32'hEB10FF00, 32'h08040201, 32'h01FE00FF), 1'b0, '0};
      directed_rows[8]  = '{block_of(32'h7F807F80, 32'hFFFFFF00, 32'h000000FF), 1'b0, '0};
      // alternating bit patterns
      directed_rows[9]  = '{block_of(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA), 1'b0, '0};
      directed_rows[10] = '{block_of(32'h55555555, 32'hAAAAAAAA, 32'h55555555), 1'b0, '0};
      // near-neutral chroma, rounding right at the half LSB
      directed_rows[11] = '{block_of(32'h23EB5A10, 32'h7F81807F, 32'h81807F80), 1'b0, '0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].blk,
                   directed_rows[i].known ? directed_rows[i].rgb
                                          : block_colours(directed_rows[i].blk), 0);

      // Random phases, each under its own register set and sender gaps
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            start <= 1'b0;
            drain();
            configure(phase);
         end
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 52;
            default: idle_pct = 12;
         endcase
         repeat (PHASE_WORDS) begin
            blk = random_block();
            send_word(blk, block_colours(blk), idle_pct);
         end
      end
      start <= 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rgb.size() != 0) begin
         colour_errors++;
         $display("%0t: %0d words never came out", $time, pending_rgb.size());
      end

      if (colour_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
